FILE: hw/rtl/dmc_pkg.sv
// ---------------------------------------------------------------------------
// Direct-mapped cache tag controller package
// Shared widths, register map, configuration record and the command and
// status records between the controller and the datapath.
// ---------------------------------------------------------------------------
package dmc_pkg;

	// Fixed field widths.
	localparam int ADDR_W  = 32;
	localparam int CNT_W   = 48;
	localparam int COST_W  = 12;
	// The offset is never shorter than two bits, so a tag fits in 30 bits.
	localparam int MIN_OB  = 2;
	localparam int MAX_OB  = 12;
	localparam int TAG_W   = ADDR_W - MIN_OB;
	localparam int ENTRY_W = TAG_W + 2;

	// Default number of cache lines.
	localparam int DMC_LINES = 1024;

	// Register port.
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = APB_AW - 2;

	localparam logic [REG_IDX_W-1:0] REG_BLOCK_SHIFT    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT_LOG = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HIT_LATENCY    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BUS_CYCLES     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MEMORY_LATENCY = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_NEXT_IS_MEMORY = 3'd5;

	// Reset values of the registers.
	localparam logic [3:0] RST_BLOCK_SHIFT    = 4'd5;
	localparam logic [3:0] RST_LINE_COUNT_LOG = 4'd10;
	localparam logic [7:0] RST_HIT_LATENCY    = 8'd1;
	localparam logic [7:0] RST_BUS_CYCLES     = 8'd0;
	localparam logic [9:0] RST_MEMORY_LATENCY = 10'd100;
	localparam logic       RST_NEXT_IS_MEMORY = 1'b1;

	// Fixed overhead of a miss and of a dirty eviction.
	localparam logic [COST_W-1:0] MISS_OVERHEAD = 12'd2;

	typedef struct packed {
		logic [3:0] block_shift;
		logic [3:0] line_count_log2;
		logic [7:0] hit_latency;
		logic [7:0] bus_cycles;
		logic [9:0] memory_latency;
		logic       next_is_memory;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_en;  // clear one line entry during the reset sweep
		logic rd_en;   // accept an item and read its line entry
		logic upd_en;  // commit the lookup and load the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;  // sweep is at the last line
	} sts_t;

endpackage

FILE: hw/rtl/dmc_regs.sv
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style register file for the cache geometry and the cost settings.
// ---------------------------------------------------------------------------
module dmc_regs import dmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes; each register keeps only its own low bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_shift     <= RST_BLOCK_SHIFT;
			cfg_q.line_count_log2 <= RST_LINE_COUNT_LOG;
			cfg_q.hit_latency     <= RST_HIT_LATENCY;
			cfg_q.bus_cycles      <= RST_BUS_CYCLES;
			cfg_q.memory_latency  <= RST_MEMORY_LATENCY;
			cfg_q.next_is_memory  <= RST_NEXT_IS_MEMORY;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BLOCK_SHIFT:    cfg_q.block_shift     <= pwdata[3:0];
				REG_LINE_COUNT_LOG: cfg_q.line_count_log2 <= pwdata[3:0];
				REG_HIT_LATENCY:    cfg_q.hit_latency     <= pwdata[7:0];
				REG_BUS_CYCLES:     cfg_q.bus_cycles      <= pwdata[7:0];
				REG_MEMORY_LATENCY: cfg_q.memory_latency  <= pwdata[9:0];
				REG_NEXT_IS_MEMORY: cfg_q.next_is_memory  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read data, zero-extended.
	always_comb begin
		unique case (reg_idx)
			REG_BLOCK_SHIFT:    prdata = APB_DW'(cfg_q.block_shift);
			REG_LINE_COUNT_LOG: prdata = APB_DW'(cfg_q.line_count_log2);
			REG_HIT_LATENCY:    prdata = APB_DW'(cfg_q.hit_latency);
			REG_BUS_CYCLES:     prdata = APB_DW'(cfg_q.bus_cycles);
			REG_MEMORY_LATENCY: prdata = APB_DW'(cfg_q.memory_latency);
			REG_NEXT_IS_MEMORY: prdata = APB_DW'(cfg_q.next_is_memory);
			default:            prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/dmc_ctrl.sv
// ---------------------------------------------------------------------------
// Cache controller state machine
// Sequences the reset sweep of the line memory, item acceptance, the lookup
// commit and the output handshake.
// ---------------------------------------------------------------------------
module dmc_ctrl import dmc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				// Commit only when the output register is free or being emptied.
				if (!out_valid_q || !out_stall) begin
					cmd.upd_en = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid: set by a commit, cleared when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/dmc_dpath.sv
// ---------------------------------------------------------------------------
// Cache tag datapath
// Line memory (tag, valid, dirty), address split, hit check, cost, running
// counters and the result register.
// ---------------------------------------------------------------------------
module dmc_dpath import dmc_pkg::*; #(
	parameter int LINES = DMC_LINES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              req_type,
	input  logic [ADDR_W-1:0] addr,
	output logic              hit,
	output logic              writeback,
	output logic [ADDR_W-1:0] victim_addr,
	output logic              fetch,
	output logic              fetch_is_store,
	output logic [COST_W-1:0] cost_cycles,
	output logic [CNT_W-1:0]  total_cycles,
	output logic [CNT_W-1:0]  hit_count,
	output logic [CNT_W-1:0]  miss_count,
	output logic [CNT_W-1:0]  load_miss_writebacks,
	output logic [CNT_W-1:0]  store_miss_writebacks
);

	localparam int IDX_W      = (LINES > 1) ? $clog2(LINES) : 1;
	// Largest power of two not above LINES, as a bit count.
	localparam int LINES_LOG2 = $clog2(LINES + 1) - 1;
	localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(LINES - 1);

	// Saturating add into a running counter.
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
	                                             input logic [COST_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + (CNT_W + 1)'(b);
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	// Entry layout: {valid, dirty, tag}.
	logic [ENTRY_W-1:0] mem [LINES];
	logic [ENTRY_W-1:0] entry_s1;

	logic [IDX_W-1:0]  clr_idx_q;
	logic [IDX_W-1:0]  idx_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic              store_s1;

	logic [3:0]        ob;
	logic [4:0]        ib;
	logic [5:0]        ts;
	logic [ADDR_W-1:0] idx_mask;
	logic [ADDR_W-1:0] idx_full;
	logic [ADDR_W-1:0] tag_full;
	logic [IDX_W-1:0]  idx_in;
	logic [TAG_W-1:0]  tag_in;

	logic              ent_valid, ent_dirty;
	logic [TAG_W-1:0]  ent_tag;
	logic              hit_c, wb_c;
	logic [ADDR_W-1:0] victim_c;
	logic [COST_W-1:0] cost_c;
	logic [COST_W-1:0] lat_hit, lat_clean, lat_dirty;

	logic              we;
	logic [IDX_W-1:0]  wa;
	logic [ENTRY_W-1:0] wd;

	logic              hit_q, wb_q, fetch_q, fstore_q;
	logic [ADDR_W-1:0] victim_q;
	logic [COST_W-1:0] cost_q;
	logic [CNT_W-1:0]  total_q, hits_q, misses_q, load_wb_q, store_wb_q;

	// Offset and index bit counts from the configuration, saturated.
	always_comb begin
		if (cfg.block_shift < 4'(MIN_OB)) begin
			ob = 4'(MIN_OB);
		end else if (cfg.block_shift > 4'(MAX_OB)) begin
			ob = 4'(MAX_OB);
		end else begin
			ob = cfg.block_shift;
		end
		if ({1'b0, cfg.line_count_log2} > 5'(LINES_LOG2)) begin
			ib = 5'(LINES_LOG2);
		end else begin
			ib = {1'b0, cfg.line_count_log2};
		end
		ts = 6'(ob) + 6'(ib);
	end

	// Address split of the incoming item.
	assign idx_mask = ~({ADDR_W{1'b1}} << ib);
	assign idx_full = (addr >> ob) & idx_mask;
	assign tag_full = addr >> ts;
	assign idx_in   = idx_full[IDX_W-1:0];
	assign tag_in   = tag_full[TAG_W-1:0];

	// Sweep counter that clears the line memory after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_en) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_idx_q == CLR_LAST);

	// Accepted item and its line entry.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			idx_s1   <= idx_in;
			tag_s1   <= tag_in;
			store_s1 <= req_type;
			entry_s1 <= mem[idx_in];
		end
	end

	// Lookup on the stored entry.
	assign ent_valid = entry_s1[ENTRY_W-1];
	assign ent_dirty = entry_s1[ENTRY_W-2];
	assign ent_tag   = entry_s1[TAG_W-1:0];
	assign hit_c     = ent_valid && (ent_tag == tag_s1);
	assign wb_c      = !hit_c && ent_valid && ent_dirty;

	// Block address of the dirty victim.
	assign victim_c  = wb_c ? ((ADDR_W'(ent_tag) << ts) | (ADDR_W'(idx_s1) << ob)) : '0;

	// Cycles charged here; toward memory a dirty miss pays memory latency twice.
	assign lat_hit   = COST_W'(cfg.hit_latency) + COST_W'(cfg.bus_cycles);
	assign lat_clean = COST_W'(cfg.memory_latency) + COST_W'(cfg.bus_cycles) + MISS_OVERHEAD;
	assign lat_dirty = COST_W'(cfg.memory_latency) + lat_clean;

	always_comb begin
		if (hit_c) begin
			cost_c = lat_hit;
		end else if (cfg.next_is_memory) begin
			cost_c = wb_c ? lat_dirty : lat_clean;
		end else begin
			cost_c = wb_c ? MISS_OVERHEAD : '0;
		end
	end

	// Line memory write: sweep clear or commit of the lookup.
	always_comb begin
		we = cmd.clr_en || cmd.upd_en;
		wa = cmd.clr_en ? clr_idx_q : idx_s1;
		wd = cmd.clr_en ? '0 : {1'b1, store_s1 || (hit_c && ent_dirty), tag_s1};
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.upd_en) begin
			hit_q    <= hit_c;
			wb_q     <= wb_c;
			victim_q <= victim_c;
			fetch_q  <= !hit_c;
			fstore_q <= !hit_c && !wb_c && store_s1;
			cost_q   <= cost_c;
		end
	end

	// Running counters; they change only when a result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			hits_q     <= '0;
			misses_q   <= '0;
			load_wb_q  <= '0;
			store_wb_q <= '0;
		end else if (cmd.upd_en) begin
			total_q    <= sat_add(total_q, cost_c);
			hits_q     <= sat_add(hits_q, COST_W'(hit_c));
			misses_q   <= sat_add(misses_q, COST_W'(!hit_c));
			load_wb_q  <= sat_add(load_wb_q, COST_W'(wb_c && !store_s1));
			store_wb_q <= sat_add(store_wb_q, COST_W'(wb_c && store_s1));
		end
	end

	assign hit                   = hit_q;
	assign writeback             = wb_q;
	assign victim_addr           = victim_q;
	assign fetch                 = fetch_q;
	assign fetch_is_store        = fstore_q;
	assign cost_cycles           = cost_q;
	assign total_cycles          = total_q;
	assign hit_count             = hits_q;
	assign miss_count            = misses_q;
	assign load_miss_writebacks  = load_wb_q;
	assign store_miss_writebacks = store_wb_q;

endmodule

FILE: hw/rtl/direct_mapped_cache_tag_controller_top.sv
// ---------------------------------------------------------------------------
// Direct-mapped write-back cache tag controller
// Looks up each load or store in a direct-mapped tag memory, reports hit,
// dirty victim and fill request, and keeps saturating access statistics.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  req_type, addr
//   out      output     out_valid/out_stall  hit .. store_miss_writebacks
//   cfg      input      APB psel/penable     paddr, pwdata, prdata
//
// An item goes through two steps: read its line entry from the single-port
// line memory, then compare, update the entry and load the result register.
// A new item is taken while the previous result still waits at the output.
// After reset the line memory is swept clear, one line a cycle, through all
// LINES lines; no item is taken until the sweep ends.
// A stalled output holds the lookup until the result register frees up.
// ---------------------------------------------------------------------------
module direct_mapped_cache_tag_controller_top import dmc_pkg::*; #(
	parameter int LINES = DMC_LINES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [ADDR_W-1:0] addr,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic              writeback,
	output logic [ADDR_W-1:0] victim_addr,
	output logic              fetch,
	output logic              fetch_is_store,
	output logic [COST_W-1:0] cost_cycles,
	output logic [CNT_W-1:0]  total_cycles,
	output logic [CNT_W-1:0]  hit_count,
	output logic [CNT_W-1:0]  miss_count,
	output logic [CNT_W-1:0]  load_miss_writebacks,
	output logic [CNT_W-1:0]  store_miss_writebacks
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// Configuration registers.
	dmc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Control state machine.
	dmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Tag memory, lookup and counters.
	dmc_dpath #(
		.LINES (LINES)
	) u_dpath (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg                   (cfg),
		.cmd                   (cmd),
		.sts                   (sts),
		.req_type              (req_type),
		.addr                  (addr),
		.hit                   (hit),
		.writeback             (writeback),
		.victim_addr           (victim_addr),
		.fetch                 (fetch),
		.fetch_is_store        (fetch_is_store),
		.cost_cycles           (cost_cycles),
		.total_cycles          (total_cycles),
		.hit_count             (hit_count),
		.miss_count            (miss_count),
		.load_miss_writebacks  (load_miss_writebacks),
		.store_miss_writebacks (store_miss_writebacks)
	);

endmodule
